// ===== hw/rtl/bpa_pkg.sv =====
// Shared types, widths and codes for the buddy page allocator.
// No dependencies; imported by every RTL module of the block.
package bpa_pkg;

  localparam int TopOrder = 10;
  localparam int MaxPages = 1 << TopOrder;
  localparam int CapW     = TopOrder + 1;
  localparam int IdxW     = TopOrder + 1;
  localparam int OrdW     = 4;
  localparam int OffW     = TopOrder;
  localparam int CntW     = 11;

  localparam logic [1:0] ActAlloc   = 2'd0;
  localparam logic [1:0] ActFree    = 2'd1;
  localparam logic [1:0] ActRebuild = 2'd2;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOSPACE,
    ST_BADSIZE,
    ST_BADOFF
  } status_e;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_LEFT,
    RD_RIGHT,
    RD_CUR,
    RD_PAR,
    RD_SIB,
    RD_PSIB
  } rd_e;

  typedef struct packed {
    logic    latch;
    logic    rb_init;
    logic    rb_step;
    logic    rd_en;
    rd_e     rd_sel;
    logic    cap_l;
    logic    descend;
    logic    claim;
    logic    climb;
    logic    up_wr;
    logic    set_st;
    status_e st;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       size_bad;
    logic       off_bad;
    logic       no_space;
    logic       at_level;
    logic       hit;
    logic       is_root;
    logic       near_root;
    logic       misalign;
    logic       rb_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== hw/rtl/bpa_ctrl.sv =====
// Sequencer of the buddy page allocator: rebuild sweep, descent, climb, ascent.
// Depends on bpa_pkg; drives bpa_dpath through cmd_t and reads sts_t.
module bpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bpa_pkg::sts_t sts_i,
  output bpa_pkg::cmd_t cmd_o
);
  import bpa_pkg::*;

  typedef enum logic [3:0] {
    S_BOOT, S_CLR, S_IDLE, S_CHK, S_AROOT, S_ARL, S_ARR, S_ANXT,
    S_CLAIM, S_UP, S_FCHK, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   rb_req_q, rb_req_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    rb_req_d = rb_req_q;
    cmd_o    = '0;
    cmd_o.st = ST_OK;
    cmd_o.rd_sel = RD_ROOT;
    case (state_q)
      S_BOOT: begin
        cmd_o.rb_init = 1'b1;
        rb_req_d = 1'b0;
        state_d = S_CLR;
      end
      S_CLR: begin
        cmd_o.rb_step = 1'b1;
        if (sts_i.rb_last) state_d = rb_req_q ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        case (sts_i.act)
          ActAlloc: begin
            if (sts_i.size_bad) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st = ST_BADSIZE;
              state_d = S_DONE;
            end else begin
              cmd_o.rd_en = 1'b1;
              cmd_o.rd_sel = RD_ROOT;
              state_d = S_AROOT;
            end
          end
          ActFree: begin
            if (sts_i.off_bad) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st = ST_BADOFF;
              state_d = S_DONE;
            end else begin
              cmd_o.rd_en = 1'b1;
              cmd_o.rd_sel = RD_CUR;
              state_d = S_FCHK;
            end
          end
          ActRebuild: begin
            cmd_o.rb_init = 1'b1;
            rb_req_d = 1'b1;
            state_d = S_CLR;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_AROOT: begin
        if (sts_i.no_space) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st = ST_NOSPACE;
          state_d = S_DONE;
        end else if (sts_i.at_level) begin
          state_d = S_CLAIM;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RD_LEFT;
          state_d = S_ARL;
        end
      end
      S_ARL: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RD_RIGHT;
        cmd_o.cap_l = 1'b1;
        state_d = S_ARR;
      end
      S_ARR: begin
        cmd_o.descend = 1'b1;
        state_d = S_ANXT;
      end
      S_ANXT: begin
        if (sts_i.at_level) begin
          state_d = S_CLAIM;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RD_LEFT;
          state_d = S_ARL;
        end
      end
      S_CLAIM: begin
        cmd_o.claim = 1'b1;
        if (sts_i.is_root) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RD_SIB;
          state_d = S_UP;
        end
      end
      S_UP: begin
        cmd_o.up_wr = 1'b1;
        if (sts_i.near_root) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RD_PSIB;
        end
      end
      S_FCHK: begin
        if (sts_i.hit) begin
          if (sts_i.misalign) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st = ST_BADOFF;
            state_d = S_DONE;
          end else begin
            state_d = S_CLAIM;
          end
        end else if (sts_i.is_root) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st = ST_BADOFF;
          state_d = S_DONE;
        end else begin
          cmd_o.climb = 1'b1;
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RD_PAR;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_BOOT;
      rb_req_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rb_req_q <= rb_req_d;
    end
  end

endmodule

// ===== hw/rtl/bpa_dpath.sv =====
// Datapath of the buddy page allocator: capacity tree memory, walk registers,
// free total and output register. Depends on bpa_pkg; steered by bpa_ctrl.
module bpa_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bpa_pkg::cmd_t              cmd_i,
  output bpa_pkg::sts_t              sts_o,
  input  logic                       cfg_we_i,
  input  logic [bpa_pkg::OrdW-1:0]   cfg_wdata_i,
  input  logic [1:0]                 in_act_i,
  input  logic [bpa_pkg::CntW-1:0]   in_cnt_i,
  input  logic [bpa_pkg::OffW-1:0]   in_off_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output bpa_pkg::status_e           out_status_o,
  output logic [bpa_pkg::OffW-1:0]   out_grant_o,
  output logic [bpa_pkg::CapW-1:0]   out_free_o
);
  import bpa_pkg::*;

  logic [CapW-1:0] mem [1 << IdxW];
  logic [CapW-1:0] rdata_q;

  logic [OrdW-1:0] order_q, bo_q;
  logic [CapW-1:0] total_q, sz_q, curv_q, cl_q, pw_q;
  logic [IdxW-1:0] idx_q;
  logic [OrdW-1:0] k_q;
  logic [1:0]      act_q;
  logic [CntW-1:0] cnt_q;
  logic [OffW-1:0] off_q;
  status_e         st_q;
  logic [OffW-1:0] grant_q;
  logic            oval_q;

  logic [CapW-1:0] pool, new_pool, wval, pval, chosen_cap_l;
  logic [OrdW-1:0] sat_ord, kk;
  logic [IdxW-1:0] raddr, waddr, child;
  logic            we;
  logic [CapW:0]   last_idx, pair_sum;
  logic [CapW-1:0] sz_m1, mx;
  logic [IdxW+TopOrder-1:0] shifted;

  assign pool     = CapW'(1) << bo_q;
  assign sat_ord  = (order_q > OrdW'(TopOrder)) ? OrdW'(TopOrder) : order_q;
  assign new_pool = CapW'(1) << sat_ord;
  assign last_idx = {pool, 1'b0} - (CapW+1)'(1);
  assign sz_m1    = sz_q - CapW'(1);
  assign shifted  = (IdxW+TopOrder)'(idx_q) << k_q;

  always_comb begin
    kk = OrdW'(TopOrder);
    for (int i = TopOrder; i >= 0; i--) begin
      if (((CntW+1)'(1) << i) >= (CntW+1)'(in_cnt_i)) kk = OrdW'(i);
    end
  end

  assign sts_o.act       = act_q;
  assign sts_o.size_bad  = (cnt_q == '0) || ((CntW+1)'(cnt_q) > (CntW+1)'(pool));
  assign sts_o.off_bad   = (CapW'(off_q) >= pool);
  assign sts_o.no_space  = (rdata_q < pw_q);
  assign sts_o.at_level  = (sz_q == pw_q);
  assign sts_o.hit       = (rdata_q == '0);
  assign sts_o.is_root   = (idx_q == IdxW'(1));
  assign sts_o.near_root = (idx_q[IdxW-1:1] == (IdxW-1)'(1));
  assign sts_o.misalign  = ((off_q & sz_m1[OffW-1:0]) != '0);
  assign sts_o.rb_last   = ({1'b0, idx_q} == last_idx);
  assign sts_o.out_free  = !oval_q || out_ready_i;

  assign chosen_cap_l = cl_q;
  always_comb begin
    if (chosen_cap_l <= rdata_q) begin
      child = (chosen_cap_l >= pw_q) ? {idx_q[IdxW-2:0], 1'b0} : {idx_q[IdxW-2:0], 1'b1};
    end else begin
      child = (rdata_q >= pw_q) ? {idx_q[IdxW-2:0], 1'b1} : {idx_q[IdxW-2:0], 1'b0};
    end
  end

  assign mx       = (curv_q > rdata_q) ? curv_q : rdata_q;
  assign pair_sum = (CapW+1)'(curv_q) + (CapW+1)'(rdata_q);
  assign pval     = ((act_q == ActFree) && (pair_sum == {sz_q, 1'b0}))
                    ? CapW'({sz_q, 1'b0}) : mx;
  assign wval     = (act_q == ActAlloc) ? '0 : sz_q;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ROOT:  raddr = IdxW'(1);
      RD_LEFT:  raddr = {idx_q[IdxW-2:0], 1'b0};
      RD_RIGHT: raddr = {idx_q[IdxW-2:0], 1'b1};
      RD_CUR:   raddr = idx_q;
      RD_PAR:   raddr = idx_q >> 1;
      RD_SIB:   raddr = idx_q ^ IdxW'(1);
      RD_PSIB:  raddr = (idx_q >> 1) ^ IdxW'(1);
      default:  raddr = idx_q;
    endcase
  end

  always_comb begin
    we    = cmd_i.rb_step || cmd_i.claim || cmd_i.up_wr;
    waddr = cmd_i.up_wr ? (idx_q >> 1) : idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= cmd_i.up_wr ? pval : (cmd_i.claim ? wval : curv_q);
    if (cmd_i.rd_en) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrdW'(TopOrder);
      bo_q    <= OrdW'(TopOrder);
      total_q <= CapW'(MaxPages);
      oval_q  <= 1'b0;
    end else begin
      if (cfg_we_i) order_q <= cfg_wdata_i;
      if (cmd_i.rb_init) begin
        bo_q    <= sat_ord;
        total_q <= new_pool;
      end
      if (cmd_i.claim) begin
        total_q <= (act_q == ActAlloc) ? total_q - pw_q : total_q + sz_q;
      end
      if (cmd_i.out_load) oval_q <= 1'b1;
      else if (out_ready_i) oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q   <= in_act_i;
      cnt_q   <= in_cnt_i;
      off_q   <= in_off_i;
      k_q     <= kk;
      pw_q    <= CapW'(1) << kk;
      st_q    <= ST_OK;
      grant_q <= '0;
      if (in_act_i == ActFree) begin
        idx_q <= IdxW'(pool) + IdxW'(in_off_i);
        sz_q  <= CapW'(1);
      end else begin
        idx_q <= IdxW'(1);
        sz_q  <= pool;
      end
    end
    if (cmd_i.rb_init) begin
      idx_q  <= IdxW'(1);
      curv_q <= new_pool;
    end
    if (cmd_i.rb_step) begin
      idx_q <= idx_q + IdxW'(1);
      if ((idx_q & (idx_q + IdxW'(1))) == '0) curv_q <= curv_q >> 1;
    end
    if (cmd_i.cap_l) cl_q <= rdata_q;
    if (cmd_i.descend) begin
      idx_q <= child;
      sz_q  <= sz_q >> 1;
    end
    if (cmd_i.climb) begin
      idx_q <= idx_q >> 1;
      sz_q  <= sz_q << 1;
    end
    if (cmd_i.claim) begin
      curv_q <= wval;
      if (act_q == ActAlloc) grant_q <= shifted[OffW-1:0] & sz_m1[OffW-1:0] | '0
                                        & '0 | (shifted[OffW-1:0] & (pool[OffW-1:0]
                                        - OffW'(1)));
    end
    if (cmd_i.up_wr) begin
      curv_q <= pval;
      idx_q  <= idx_q >> 1;
      sz_q   <= sz_q << 1;
    end
    if (cmd_i.set_st) st_q <= cmd_i.st;
    if (cmd_i.out_load) begin
      out_status_o <= st_q;
      out_grant_o  <= grant_q;
      out_free_o   <= total_q;
    end
  end

  assign out_valid_o = oval_q;

endmodule

// ===== hw/rtl/buddy_page_allocator_unit.sv =====
// Buddy page allocator: request stream in, one result beat per request out.
// Handshake in and out; requests carry the action in tuser. Result beats carry
// the status in tuser and the granted offset and free page count in tdata.
// One request at a time: allocate descends the tree level by level and then
// ascends it; free climbs to the claimed node and then ascends; a rebuild
// writes one tree node per cycle.
// The tree memory has one read and one write port; each level visit waits
// on its registered read data.
// After reset the tree is built for order 10 by a boot step and a sweep over
// every tree node, during which s_axis_tready stays low; pool_order may be
// written at any time and takes effect at the next rebuild request.
// A finished result sits in an output register; the next request is accepted
// while it waits. When the receiver stalls with one result held, the block
// finishes the following request and then holds it until the register frees.
module buddy_page_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // page_count[10:0], block_offset[20:11]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // granted_offset[9:0], pages_free[20:10]
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);
  import bpa_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  status_e         status;
  logic [OffW-1:0] grant;
  logic [CapW-1:0] pages_free;

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpa_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_act_i     (s_axis_tuser),
    .in_cnt_i     (s_axis_tdata[10:0]),
    .in_off_i     (s_axis_tdata[20:11]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (status),
    .out_grant_o  (grant),
    .out_free_o   (pages_free)
  );

  assign m_axis_tdata = {3'b000, pages_free, grant};
  assign m_axis_tuser = status;

endmodule

// ===== hw/rtl/bpa_checker.sv =====
// Port-level checks for buddy_page_allocator_unit, bound to the top level.
// Depends on bpa_pkg for status codes and the pool size limit.
module bpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import bpa_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[9:0] != '0) |-> m_axis_tuser == ST_OK)
    else $error("nonzero offset on failed request");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[20:10] <= 11'(MaxPages))
    else $error("free page count above pool limit");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request accepted while one is in progress");

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
